// File: rtl/core/sfrd_pkg.sv
`default_nettype none

package sfrd_pkg;

  // Frame layout
  localparam int unsigned NUM_CHANNELS_DEF = 16;
  localparam int unsigned FRAME_BYTES      = 25;
  localparam int unsigned DATA_BYTES       = 22;
  localparam int unsigned STORE_W          = DATA_BYTES * 8;

  localparam logic [7:0] HEADER_BYTE = 8'h0F;
  localparam logic [7:0] FOOTER_STD  = 8'h00;

  // Field widths
  localparam int unsigned RAW_W  = 11;
  localparam int unsigned VAL_W  = 12;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 12;

  // Byte positions within a frame (header is position 0 while hunting)
  localparam logic [POS_W-1:0] POS_WAIT      = 5'd0;
  localparam logic [POS_W-1:0] POS_LAST_DATA = POS_W'(DATA_BYTES);
  localparam logic [POS_W-1:0] POS_FOOTER    = POS_W'(FRAME_BYTES - 1);

  // Input command codes
  localparam logic CMD_BYTE   = 1'b0;
  localparam logic CMD_RESYNC = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_RAW_OFFSET  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_OUTPUT_BASE = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_OUTPUT_MIN  = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_OUTPUT_MAX  = 2'd3;

  // Configuration reset values
  localparam logic [RAW_W-1:0] RAW_OFFSET_RST  = 11'd282;
  localparam logic [VAL_W-1:0] OUTPUT_BASE_RST = 12'd1050;
  localparam logic [VAL_W-1:0] OUTPUT_MIN_RST  = 12'd1050;
  localparam logic [VAL_W-1:0] OUTPUT_MAX_RST  = 12'd1950;

  // Controller to datapath
  typedef struct packed {
    logic             byte_shift;   // push a data byte into the frame store
    logic             footer_load;  // latch footer status
    logic             calc_diff;    // take next raw channel, subtract offset
    logic             calc_scale;   // scale by 5/8 and add base
    logic             out_load;     // clamp and load output register
    logic [IDX_W-1:0] chan;
    logic             last;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hdr_match;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/sfrd_ctrl.sv
`default_nettype none

module sfrd_ctrl #(
  parameter int unsigned NUM_CHANNELS = sfrd_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_cmd,
  output      logic                 in_stall,
  input  wire sfrd_pkg::ctrl_sts_t  sts,
  output      sfrd_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIFF,
    S_SCALE,
    S_CLAMP
  } state_t;

  localparam logic [sfrd_pkg::IDX_W-1:0] LAST_CHAN = sfrd_pkg::IDX_W'(NUM_CHANNELS - 1);

  state_t                         state_r, state_nxt;
  logic [sfrd_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [sfrd_pkg::IDX_W-1:0]     chan_r, chan_nxt;
  logic                           in_xfer;
  logic                           is_last;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign is_last  = (chan_r == LAST_CHAN);

  // Next-state and command decode
  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    chan_nxt        = chan_r;
    cmd             = '0;
    cmd.chan        = chan_r;
    cmd.last        = is_last;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_cmd == sfrd_pkg::CMD_RESYNC) begin
            pos_nxt = sfrd_pkg::POS_WAIT;
          end else if (pos_r == sfrd_pkg::POS_WAIT || pos_r > sfrd_pkg::POS_FOOTER) begin
            // hunting for the header; other bytes are dropped
            pos_nxt = sts.hdr_match ? 5'd1 : sfrd_pkg::POS_WAIT;
          end else if (pos_r <= sfrd_pkg::POS_LAST_DATA) begin
            cmd.byte_shift = 1'b1;
            pos_nxt        = pos_r + 5'd1;
          end else if (pos_r < sfrd_pkg::POS_FOOTER) begin
            // flags byte, discarded
            pos_nxt = pos_r + 5'd1;
          end else begin
            // footer: frame complete, start unpacking
            cmd.footer_load = 1'b1;
            pos_nxt         = sfrd_pkg::POS_WAIT;
            chan_nxt        = '0;
            state_nxt       = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        cmd.calc_diff = 1'b1;
        state_nxt     = S_SCALE;
      end
      S_SCALE: begin
        cmd.calc_scale = 1'b1;
        state_nxt      = S_CLAMP;
      end
      S_CLAMP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            chan_nxt  = chan_r + 4'd1;
            state_nxt = S_DIFF;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= sfrd_pkg::POS_WAIT;
      chan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      chan_r  <= chan_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sfrd_dp.sv
`default_nettype none

module sfrd_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [7:0]                   in_rx_byte,
  input  wire logic                         cfg_we,
  input  wire logic [sfrd_pkg::CFG_AW-1:0]  cfg_index,
  input  wire logic [sfrd_pkg::CFG_DW-1:0]  cfg_data,
  input  wire sfrd_pkg::ctrl_cmd_t          cmd,
  output      sfrd_pkg::ctrl_sts_t          sts,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic [sfrd_pkg::IDX_W-1:0]   out_channel_index,
  output      logic [sfrd_pkg::VAL_W-1:0]   out_channel_value,
  output      logic [sfrd_pkg::RAW_W-1:0]   out_raw_value,
  output      logic                         out_footer_nonstandard,
  output      logic                         out_last
);

  localparam int unsigned RAW_W = sfrd_pkg::RAW_W;
  localparam int unsigned VAL_W = sfrd_pkg::VAL_W;
  localparam int unsigned MAP_W = VAL_W + 2;   // signed, covers base +/- 1279

  // Configuration registers
  logic [RAW_W-1:0] raw_offset_r;
  logic [VAL_W-1:0] output_base_r, output_min_r, output_max_r;

  // Frame store as a byte shift line; channel 0 sits at the bottom
  logic [sfrd_pkg::STORE_W-1:0] store_r;
  logic                         footer_bad_r;

  // Per-channel arithmetic stages
  logic [RAW_W-1:0]        raw_r;
  logic [RAW_W-1:0]        mag_r;
  logic                    neg_r;
  logic signed [MAP_W-1:0] mapped_r;

  // Output register
  logic                    out_valid_r;
  logic [sfrd_pkg::IDX_W-1:0] out_idx_r;
  logic [VAL_W-1:0]        out_val_r;
  logic [RAW_W-1:0]        out_raw_r;
  logic                    out_foot_r;
  logic                    out_last_r;

  logic signed [RAW_W:0]   diff;
  logic [RAW_W:0]          diff_abs;
  logic [RAW_W+2:0]        prod;
  logic [RAW_W-1:0]        q;
  logic signed [MAP_W-1:0] mapped_nxt;
  logic signed [MAP_W-1:0] clamp_hi;
  logic [VAL_W-1:0]        clamped;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_offset_r  <= sfrd_pkg::RAW_OFFSET_RST;
      output_base_r <= sfrd_pkg::OUTPUT_BASE_RST;
      output_min_r  <= sfrd_pkg::OUTPUT_MIN_RST;
      output_max_r  <= sfrd_pkg::OUTPUT_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfrd_pkg::CFG_RAW_OFFSET:  raw_offset_r  <= cfg_data[RAW_W-1:0];
        sfrd_pkg::CFG_OUTPUT_BASE: output_base_r <= cfg_data;
        sfrd_pkg::CFG_OUTPUT_MIN:  output_min_r  <= cfg_data;
        sfrd_pkg::CFG_OUTPUT_MAX:  output_max_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Subtract offset, split into sign and magnitude
  assign diff     = $signed({1'b0, store_r[RAW_W-1:0]}) - $signed({1'b0, raw_offset_r});
  assign diff_abs = diff[RAW_W] ? (~diff + 1'b1) : diff;

  // mag * 5 / 8 rounded half up, then apply sign around base
  assign prod       = {mag_r, 2'b00} + {2'b00, mag_r} + (RAW_W+3)'(4);
  assign q          = prod[RAW_W+2:3];
  assign mapped_nxt = neg_r ? ($signed({2'b00, output_base_r}) - $signed({3'b000, q}))
                            : ($signed({2'b00, output_base_r}) + $signed({3'b000, q}));

  // Upper bound first, then lower
  assign clamp_hi = (mapped_r > $signed({2'b00, output_max_r})) ?
                    $signed({2'b00, output_max_r}) : mapped_r;
  assign clamped  = (clamp_hi < $signed({2'b00, output_min_r})) ?
                    output_min_r : clamp_hi[VAL_W-1:0];

  // Frame store and arithmetic stages
  always_ff @(posedge clk) begin
    if (cmd.byte_shift) begin
      store_r <= {in_rx_byte, store_r[sfrd_pkg::STORE_W-1:8]};
    end else if (cmd.calc_diff) begin
      store_r <= {{RAW_W{1'b0}}, store_r[sfrd_pkg::STORE_W-1:RAW_W]};
    end
    if (cmd.footer_load) begin
      footer_bad_r <= (in_rx_byte != sfrd_pkg::FOOTER_STD);
    end
    if (cmd.calc_diff) begin
      raw_r <= store_r[RAW_W-1:0];
      mag_r <= diff_abs[RAW_W-1:0];
      neg_r <= diff[RAW_W];
    end
    if (cmd.calc_scale) begin
      mapped_r <= mapped_nxt;
    end
  end

  // Output register: holds while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_idx_r  <= cmd.chan;
      out_val_r  <= clamped;
      out_raw_r  <= raw_r;
      out_foot_r <= footer_bad_r;
      out_last_r <= cmd.last;
    end
  end

  assign sts.hdr_match = (in_rx_byte == sfrd_pkg::HEADER_BYTE);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid              = out_valid_r;
  assign out_channel_index      = out_idx_r;
  assign out_channel_value      = out_val_r;
  assign out_raw_value          = out_raw_r;
  assign out_footer_nonstandard = out_foot_r;
  assign out_last               = out_last_r;

endmodule

`default_nettype wire

// File: rtl/core/sbus_frame_receiver_decoder_unit.sv
`default_nettype none

// SBUS frame receiver and channel decoder. Bytes other than the 0x0F header
// are dropped while hunting, then the 22 data bytes are collected, the flags
// byte is discarded and the footer byte is checked. On the footer transfer
// the block stalls its input and emits NUM_CHANNELS results, one per channel,
// each passing in turn through the subtract, scale and clamp steps of the
// shared datapath; the clamp step waits while the result side stalls. The
// last result of a frame may wait in the output register while the next
// frame's bytes are taken. A resync transfer (cmd = 1) returns the parser to
// header hunting. Configuration (cfg_ready is always high) should be written
// only while no frame results are outstanding.

module sbus_frame_receiver_decoder_unit #(
  parameter int unsigned NUM_CHANNELS = sfrd_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // received byte channel
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic                         in_cmd,
  input  wire logic [7:0]                   in_rx_byte,
  // channel results
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic [sfrd_pkg::IDX_W-1:0]   out_channel_index,
  output      logic [sfrd_pkg::VAL_W-1:0]   out_channel_value,
  output      logic [sfrd_pkg::RAW_W-1:0]   out_raw_value,
  output      logic                         out_footer_nonstandard,
  output      logic                         out_last,
  // configuration writes
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [sfrd_pkg::CFG_AW-1:0]  cfg_index,
  input  wire logic [sfrd_pkg::CFG_DW-1:0]  cfg_data
);

  sfrd_pkg::ctrl_cmd_t cmd;
  sfrd_pkg::ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  sfrd_ctrl #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfrd_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_rx_byte             (in_rx_byte),
    .cfg_we                 (cfg_valid && cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .cmd                    (cmd),
    .sts                    (sts),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_channel_index      (out_channel_index),
    .out_channel_value      (out_channel_value),
    .out_raw_value          (out_raw_value),
    .out_footer_nonstandard (out_footer_nonstandard),
    .out_last               (out_last)
  );

endmodule

`default_nettype wire

// File: rtl/core/sfrd_checker.sv
`default_nettype none

module sfrd_checker #(
  parameter int unsigned NUM_CHANNELS = sfrd_pkg::NUM_CHANNELS_DEF
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [sfrd_pkg::IDX_W-1:0] out_channel_index,
  input wire logic [sfrd_pkg::VAL_W-1:0] out_channel_value,
  input wire logic                       out_last
);

  localparam logic [sfrd_pkg::IDX_W-1:0] LAST_CHAN = sfrd_pkg::IDX_W'(NUM_CHANNELS - 1);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_channel_value))
    else $error("stalled result changed");

  // The frame-end flag sits on the final channel only
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_channel_index == LAST_CHAN)))
    else $error("last flag does not match channel index");

  // Input stays stalled while a frame is still being emitted
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input accepted mid-frame");

  // Reset clears the result side
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sbus_frame_receiver_decoder_unit sfrd_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_sfrd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_channel_index (out_channel_index),
  .out_channel_value (out_channel_value),
  .out_last          (out_last)
);

`default_nettype wire
